// ===== src/cets_pkg.sv =====
// Package for the cold entry top-N selector: shared constants, list entry
// type, cell control codes and controller states. No dependencies.
package cets_pkg;

  // Default number of tracked entries and list depth
  localparam int MAX_ENTRIES_DEF = 64;

  // Field widths
  localparam int SLOT_W   = 6;
  localparam int SCORE_W  = 29;
  localparam int IDLE_W   = 6;
  localparam int FAULT_W  = 32;
  localparam int RSS_W    = 32;
  localparam int RSS_CL_W = 20;
  localparam int SECS_W   = 16;
  localparam int TOP_W    = 7;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLING   = 1'd1;

  // Register reset values
  localparam logic [TOP_W-1:0]  TOP_COUNT_RST = 7'd8;
  localparam logic [SECS_W-1:0] COOLING_RST   = 16'd30;

  // Scoring constants
  localparam logic [IDLE_W-1:0]   IDLE_LIMIT   = 6'd60;
  localparam logic [RSS_W-1:0]    RSS_FLOOR_KB = 32'd1024;
  localparam logic [RSS_W-1:0]    RSS_CAP_KB   = 32'd1024000;
  localparam logic [TOP_W-1:0]    RESULT_CAP   = 7'd64;

  // One held list entry
  typedef struct packed {
    logic               vld;
    logic [SLOT_W-1:0]  slot;
    logic [SCORE_W-1:0] score;
  } entry_t;

  // What every cell of the chain does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_CLEAR
  } cell_op_t;

  // Control broadcast to the chain
  typedef struct packed {
    cell_op_t op;
    entry_t   ent;
  } cell_ctl_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCORE,
    ST_INSERT,
    ST_EMIT
  } state_t;

endpackage

// ===== src/cets_in_if.sv =====
// Input channel of the cold entry top-N selector: one record word.
// Depends on cets_pkg for field widths.
interface cets_in_if;
  logic                          valid;
  logic                          ready;
  logic [cets_pkg::SLOT_W-1:0]   slot;
  logic                          is_background;
  logic [cets_pkg::FAULT_W-1:0]  minor_faults;
  logic [cets_pkg::FAULT_W-1:0]  major_faults;
  logic [cets_pkg::RSS_W-1:0]    resident_kb;
  logic                          swapped;
  logic                          was_hinted;
  logic [cets_pkg::SECS_W-1:0]   seconds_since_hint;
  logic                          last_of_round;

  modport source (
    output valid, slot, is_background, minor_faults, major_faults, resident_kb,
           swapped, was_hinted, seconds_since_hint, last_of_round,
    input  ready
  );
  modport sink (
    input  valid, slot, is_background, minor_faults, major_faults, resident_kb,
           swapped, was_hinted, seconds_since_hint, last_of_round,
    output ready
  );
endinterface

// ===== src/cets_out_if.sv =====
// Result channel of the cold entry top-N selector: one candidate word.
// Depends on cets_pkg for field widths.
interface cets_out_if;
  logic                          valid;
  logic                          ready;
  logic                          candidate_valid;
  logic [cets_pkg::SLOT_W-1:0]   candidate_slot;
  logic [cets_pkg::SCORE_W-1:0]  score_key;
  logic                          last_result;

  modport source (
    output valid, candidate_valid, candidate_slot, score_key, last_result,
    input  ready
  );
  modport sink (
    input  valid, candidate_valid, candidate_slot, score_key, last_result,
    output ready
  );
endinterface

// ===== src/cets_cell.sv =====
// One cell of the sorted candidate chain: holds a single entry, takes the
// new word or its neighbor's entry on insert, and shifts toward the head.
// Depends on cets_pkg.
module cets_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  cets_pkg::cell_ctl_t ctl,
  input  cets_pkg::entry_t   prev_ent,
  input  logic               prev_keep,
  input  cets_pkg::entry_t   next_ent,
  output cets_pkg::entry_t   ent,
  output logic               keep
);

  cets_pkg::entry_t ent_r;
  cets_pkg::entry_t ent_nxt;

  // Keep own entry when it ranks at or above the new word (ties stay ahead)
  assign keep = ent_r.vld && (ent_r.score >= ctl.ent.score);
  assign ent  = ent_r;

  // Pick next contents
  always_comb begin
    ent_nxt = ent_r;
    case (ctl.op)
      cets_pkg::CELL_HOLD: begin
        ent_nxt = ent_r;
      end
      cets_pkg::CELL_INSERT: begin
        if (keep) begin
          ent_nxt = ent_r;
        end else if (prev_keep) begin
          ent_nxt     = ctl.ent;
          ent_nxt.vld = 1'b1;
        end else begin
          ent_nxt = prev_ent;
        end
      end
      cets_pkg::CELL_SHIFT: begin
        ent_nxt = next_ent;
      end
      cets_pkg::CELL_CLEAR: begin
        ent_nxt     = ent_r;
        ent_nxt.vld = 1'b0;
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  // Hold entry; reset clears the valid flag only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

// ===== src/cets_idle.sv =====
// Per-slot idle counter store with read-modify-write update: one registered
// read, then saturating increment or clear and write back. Depends on cets_pkg.
module cets_idle #(
  parameter int MAX_ENTRIES = cets_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [cets_pkg::SLOT_W-1:0]   rd_slot,
  input  logic                          wr_en,
  input  logic                          no_faults,
  output logic [cets_pkg::IDLE_W-1:0]   idle_new
);

  // Slots are 6 bits wide, so at most 64 counters are reachable
  localparam int DEPTH = (MAX_ENTRIES < (1 << cets_pkg::SLOT_W)) ?
                         MAX_ENTRIES : (1 << cets_pkg::SLOT_W);
  localparam int IW    = $clog2(DEPTH);

  logic [cets_pkg::IDLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            vld_r;
  logic [IW-1:0]               idx_r;
  logic [cets_pkg::IDLE_W-1:0] rd_data_r;
  logic                        rd_vld_r;
  logic [cets_pkg::IDLE_W-1:0] idle_cur;
  logic [IW-1:0]               rd_idx;

  assign rd_idx = rd_slot[IW-1:0];

  // Registered read of counter and its valid flag
  always_ff @(posedge clk) begin
    if (rd_en) begin
      idx_r     <= rd_idx;
      rd_data_r <= mem[rd_idx];
      rd_vld_r  <= vld_r[rd_idx];
    end
  end

  // Saturating count on a quiet sample, clear on any fault
  always_comb begin
    idle_cur = rd_vld_r ? rd_data_r : '0;
    if (!no_faults) begin
      idle_new = '0;
    end else if (idle_cur < cets_pkg::IDLE_LIMIT) begin
      idle_new = idle_cur + cets_pkg::IDLE_W'(1);
    end else begin
      idle_new = cets_pkg::IDLE_LIMIT;
    end
  end

  // Write back counter
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= idle_new;
    end
  end

  // Mark written counters; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[idx_r] <= 1'b1;
    end
  end

endmodule

// ===== src/cold_entry_top_n_selector_top.sv =====
// Cold entry top-N selector: top level with controller, idle store and chain.
// Depends on cets_pkg, cets_in_if, cets_out_if, cets_cell and cets_idle.
//
// Each record passes through accept (the idle counter read is issued at
// the accepting edge), score multiply together with the counter write, then
// insertion into the sorted chain; no new record is accepted until it is done.
// The record that closes a round then reports each candidate, or the empty
// marker, holding while the result side stalls; the output register is the pacing point
// of the report, which pops one candidate from the head of the chain per
// cycle unless the result side stalls. Idle counters start at zero right after reset with no sweep.
module cold_entry_top_n_selector_top #(
  parameter int MAX_ENTRIES = cets_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  cets_in_if.sink                          in_ch,
  cets_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [cets_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [cets_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  // Configuration
  logic [cets_pkg::TOP_W-1:0]  top_count_r;
  logic [cets_pkg::SECS_W-1:0] cooling_r;

  // Controller
  cets_pkg::state_t state_r, state_nxt;
  logic                        in_acc;
  logic                        out_load;
  logic                        emit_done;

  // Item under work
  logic [cets_pkg::SLOT_W-1:0]   slot_r;
  logic                          act_r;
  logic                          quiet_r;
  logic [cets_pkg::RSS_CL_W-1:0] rss_r;
  logic                          swap_r;
  logic                          cool_r;
  logic                          last_r;
  logic [cets_pkg::RSS_CL_W-1:0] rss_cl;
  logic                          in_range;

  // Score stage
  logic [cets_pkg::IDLE_W-1:0]   idle_new;
  logic [25:0]                   prod;
  logic [cets_pkg::SCORE_W-1:0]  score;
  logic [cets_pkg::SCORE_W-1:0]  score_r;
  logic                          list_ok_r;

  // List bookkeeping
  logic [CW-1:0]                 held_r, held_nxt;
  logic [cets_pkg::TOP_W-1:0]    held_cap;
  logic [cets_pkg::TOP_W-1:0]    rem_r, rem_nxt;

  // Chain
  cets_pkg::cell_ctl_t           cell_ctl;
  cets_pkg::entry_t              cell_ent  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]        cell_keep;

  // Output register
  logic                          out_vld_r;
  logic                          out_cand_r;
  logic [cets_pkg::SLOT_W-1:0]   out_slot_r;
  logic [cets_pkg::SCORE_W-1:0]  out_score_r;
  logic                          out_last_r;

  assign in_ch.ready            = (state_r == cets_pkg::ST_IDLE);
  assign in_acc                 = in_ch.valid && in_ch.ready;
  assign out_ch.valid           = out_vld_r;
  assign out_ch.candidate_valid = out_cand_r;
  assign out_ch.candidate_slot  = out_slot_r;
  assign out_ch.score_key       = out_score_r;
  assign out_ch.last_result     = out_last_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= cets_pkg::TOP_COUNT_RST;
      cooling_r   <= cets_pkg::COOLING_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        cets_pkg::CFG_TOP_COUNT: top_count_r <= cfg_wdata[cets_pkg::TOP_W-1:0];
        cets_pkg::CFG_COOLING:   cooling_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Clamp resident size and check slot range at the input
  always_comb begin
    if (in_ch.resident_kb < cets_pkg::RSS_FLOOR_KB) begin
      rss_cl = cets_pkg::RSS_CL_W'(cets_pkg::RSS_FLOOR_KB);
    end else if (in_ch.resident_kb > cets_pkg::RSS_CAP_KB) begin
      rss_cl = cets_pkg::RSS_CL_W'(cets_pkg::RSS_CAP_KB);
    end else begin
      rss_cl = in_ch.resident_kb[cets_pkg::RSS_CL_W-1:0];
    end
    in_range = (32'(in_ch.slot) < 32'(MAX_ENTRIES));
  end

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r  <= in_ch.slot;
      act_r   <= in_ch.is_background && in_range;
      quiet_r <= (in_ch.minor_faults == '0) && (in_ch.major_faults == '0);
      rss_r   <= rss_cl;
      swap_r  <= in_ch.swapped;
      cool_r  <= in_ch.was_hinted && (in_ch.seconds_since_hint < cooling_r);
      last_r  <= in_ch.last_of_round;
    end
  end

  // Idle counter store
  cets_idle #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_idle (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_acc),
    .rd_slot   (in_ch.slot),
    .wr_en     ((state_r == cets_pkg::ST_SCORE) && act_r),
    .no_faults (quiet_r),
    .idle_new  (idle_new)
  );

  // Score key: clamped size times idle times 6 or 5
  always_comb begin
    prod  = 26'(rss_r) * 26'(idle_new);
    score = {1'b0, prod, 2'b00} + (swap_r ? {2'b00, prod, 1'b0} : {3'b000, prod});
  end

  always_ff @(posedge clk) begin
    if (state_r == cets_pkg::ST_SCORE) begin
      score_r   <= score;
      list_ok_r <= act_r && (score != '0) && !cool_r;
    end
  end

  // Sorted chain, head at cell 0
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    cets_pkg::entry_t prev_ent;
    cets_pkg::entry_t next_ent;
    logic             prev_keep;

    if (i == 0) begin : g_head
      assign prev_ent  = '0;
      assign prev_keep = 1'b1;
    end else begin : g_body
      assign prev_ent  = cell_ent[i-1];
      assign prev_keep = cell_keep[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_mid
      assign next_ent = cell_ent[i+1];
    end

    cets_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .prev_ent  (prev_ent),
      .prev_keep (prev_keep),
      .next_ent  (next_ent),
      .ent       (cell_ent[i]),
      .keep      (cell_keep[i])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cets_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = cets_pkg::ST_SCORE;
      end
      cets_pkg::ST_SCORE: begin
        state_nxt = cets_pkg::ST_INSERT;
      end
      cets_pkg::ST_INSERT: begin
        state_nxt = last_r ? cets_pkg::ST_EMIT : cets_pkg::ST_IDLE;
      end
      cets_pkg::ST_EMIT: begin
        if (emit_done) state_nxt = cets_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = cets_pkg::ST_IDLE;
      end
    endcase
  end

  // Controller outputs: chain op, held count, report count
  always_comb begin
    cell_ctl.op     = cets_pkg::CELL_HOLD;
    cell_ctl.ent    = '0;
    cell_ctl.ent.vld   = 1'b1;
    cell_ctl.ent.slot  = slot_r;
    cell_ctl.ent.score = score_r;
    held_nxt  = held_r;
    rem_nxt   = rem_r;
    held_cap  = '0;
    out_load  = 1'b0;
    emit_done = 1'b0;
    case (state_r)
      cets_pkg::ST_IDLE: begin
      end
      cets_pkg::ST_SCORE: begin
      end
      cets_pkg::ST_INSERT: begin
        if (list_ok_r) begin
          cell_ctl.op = cets_pkg::CELL_INSERT;
          if (32'(held_r) < 32'(MAX_ENTRIES)) held_nxt = held_r + CW'(1);
        end
        held_cap = (32'(held_nxt) > 32'(cets_pkg::RESULT_CAP)) ?
                   cets_pkg::RESULT_CAP : cets_pkg::TOP_W'(held_nxt);
        rem_nxt  = (top_count_r < held_cap) ? top_count_r : held_cap;
      end
      cets_pkg::ST_EMIT: begin
        out_load = !out_vld_r || out_ch.ready;
        if (out_load) begin
          if (rem_r <= cets_pkg::TOP_W'(1)) begin
            emit_done   = 1'b1;
            cell_ctl.op = cets_pkg::CELL_CLEAR;
            held_nxt    = '0;
          end else begin
            cell_ctl.op = cets_pkg::CELL_SHIFT;
            rem_nxt     = rem_r - cets_pkg::TOP_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Advance controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cets_pkg::ST_IDLE;
      held_r  <= '0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // Output register: load head candidate or empty marker, drop on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (rem_r == '0) begin
        out_cand_r  <= 1'b0;
        out_slot_r  <= '0;
        out_score_r <= '0;
      end else begin
        out_cand_r  <= 1'b1;
        out_slot_r  <= cell_ent[0].slot;
        out_score_r <= cell_ent[0].score;
      end
      out_last_r <= (rem_r <= cets_pkg::TOP_W'(1));
    end
  end

endmodule

// ===== src/cets_chk.sv =====
// Port-level checker for the cold entry top-N selector result channel,
// bound to the top level. Depends on cets_pkg for field widths.
module cets_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          cand_valid,
  input logic [cets_pkg::SLOT_W-1:0]   cand_slot,
  input logic [cets_pkg::SCORE_W-1:0]  score_key,
  input logic                          last_result
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cand_valid) &&
    $stable(cand_slot) && $stable(score_key) && $stable(last_result))
    else $error("result word changed while stalled");

  // Empty marker is all zero and closes the round
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !cand_valid |-> cand_slot == '0 && score_key == '0 && last_result)
    else $error("malformed empty marker");

  // Listed candidates never carry a zero score
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cand_valid |-> score_key != '0)
    else $error("candidate with zero score");

  // No result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cold_entry_top_n_selector_top cets_chk u_cets_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .cand_valid  (out_ch.candidate_valid),
  .cand_slot   (out_ch.candidate_slot),
  .score_key   (out_ch.score_key),
  .last_result (out_ch.last_result)
);
